// ----- rtl/clu_pkg.sv -----
// Shared types, constants and the 9-3-3-1 blend for the chroma line upsampler.
// No dependencies.
package clu_pkg;

    localparam int SAMPLE_BITS        = 8;
    localparam int LINE_W_BITS        = 14;
    localparam int COL_BITS           = 13;
    localparam int MAX_LINE_WIDTH_DEF = 16383;
    localparam int RESULTS            = 3;
    localparam int CNT_BITS           = 2;
    localparam int ADDR_BITS          = 3;
    localparam int DATA_BITS          = 32;
    localparam int SUM_BITS           = 12;
    localparam logic [SUM_BITS-1:0] ROUND = 12'd8;

    // register index, taken from paddr[2]
    localparam logic REG_LINE_WIDTH = 1'b0;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t u;
        sample_t v;
    } chroma_t;

    typedef struct packed {
        chroma_t                c;
        logic [LINE_W_BITS-1:0] col;
        logic                   line_last;
    } pixel_t;

    typedef struct packed {
        pixel_t [RESULTS-1:0] pix;
        logic [CNT_BITS-1:0]  cnt;
    } batch_t;

    // a: above near, b: above far, c: here near, d: here far
    function automatic sample_t blend(input logic odd, input sample_t a, input sample_t b,
                                      input sample_t c, input sample_t d);
        logic [SUM_BITS-1:0] n9;
        logic [SUM_BITS-1:0] n3;
        logic [SUM_BITS-1:0] n1;
        logic [SUM_BITS-1:0] s;
        if (odd)
        begin
            n9 = {4'd0, a};
            n3 = {4'd0, b} + {4'd0, c};
            n1 = {4'd0, d};
        end
        else
        begin
            n9 = {4'd0, c};
            n3 = {4'd0, d} + {4'd0, a};
            n1 = {4'd0, b};
        end
        s = (n9 << 3) + n9 + (n3 << 1) + n3 + n1 + ROUND;
        return s[SUM_BITS-1:4];
    endfunction

endpackage

// ----- rtl/clu_lane.sv -----
// One interpolation lane: blends a 2x2 chroma square for U and V.
// Depends on clu_pkg.
module clu_lane
(
    input  logic             odd,
    input  clu_pkg::chroma_t above_near,
    input  clu_pkg::chroma_t above_far,
    input  clu_pkg::chroma_t here_near,
    input  clu_pkg::chroma_t here_far,
    output clu_pkg::chroma_t result
);

    assign result.u = clu_pkg::blend(odd, above_near.u, above_far.u, here_near.u, here_far.u);
    assign result.v = clu_pkg::blend(odd, above_near.v, above_far.v, here_near.v, here_far.v);

endmodule

// ----- rtl/clu_merge.sv -----
// Result buffer: takes the lane outputs of one column and sends them one beat at a time.
// Depends on clu_pkg.
module clu_merge
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  clu_pkg::batch_t batch,
    output logic            take_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output clu_pkg::pixel_t pixel,
    output logic            run_last
);

    clu_pkg::pixel_t [clu_pkg::RESULTS-1:0] buf_reg;
    clu_pkg::pixel_t [clu_pkg::RESULTS-1:0] buf_next;
    logic [clu_pkg::CNT_BITS-1:0]           cnt_reg;
    logic [clu_pkg::CNT_BITS-1:0]           cnt_next;
    logic                                   beat;

    assign out_valid = (cnt_reg != '0);
    assign beat      = out_valid && out_ready;
    assign take_ok   = (cnt_reg == '0) || ((cnt_reg == 2'd1) && out_ready);
    assign pixel     = buf_reg[0];
    assign run_last  = (cnt_reg == 2'd1);

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            buf_next = batch.pix;
            cnt_next = batch.cnt;
        end
        else if (beat)
        begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == '0) || ((cnt_reg == 2'd1) && out_ready))
        else $error("column loaded over undelivered pixels");
    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (batch.cnt != '0) && (batch.cnt <= 2'd3))
        else $error("column with no pixels");
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> cnt_reg == $past(batch.cnt))
        else $error("pixel count not taken on load");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && !load) |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("pixel count not stepped on beat");
`endif

endmodule

// ----- rtl/chroma_line_upsampler_core.sv -----
// Top level of the 4:2:0 chroma line upsampler: column state, APB register, three lanes.
// Depends on clu_pkg, clu_lane, clu_merge.
//
//  channel | handshake         | payload
//  --------+-------------------+---------------------------------------------------
//  in      | in_valid/in_ready | above_u, above_v, here_u, here_v, mode
//  out     | out_valid/out_ready | u_out, v_out, pixel_column, run_last, line_last
//  cfg     | APB psel/penable  | paddr, pwdata, prdata (line_width at 0x0)
//
// A column gives one to three pixels (two in the line body), one beat per cycle while out_ready is high.
// The three lanes blend all pixels of a column in the accept cycle; the buffer sets the rate.
// The next column is taken in the cycle its predecessor's last pixel leaves.
// Reset clears the column counter and previous samples; line_width resets to 1.
// Output stalls hold the buffer and drop in_ready.
module chroma_line_upsampler_core
#(
    parameter int MAX_LINE_WIDTH = clu_pkg::MAX_LINE_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [clu_pkg::SAMPLE_BITS-1:0]   above_u,
    input  logic [clu_pkg::SAMPLE_BITS-1:0]   above_v,
    input  logic [clu_pkg::SAMPLE_BITS-1:0]   here_u,
    input  logic [clu_pkg::SAMPLE_BITS-1:0]   here_v,
    input  logic                              mode,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [clu_pkg::SAMPLE_BITS-1:0]   u_out,
    output logic [clu_pkg::SAMPLE_BITS-1:0]   v_out,
    output logic [clu_pkg::LINE_W_BITS-1:0]   pixel_column,
    output logic                              run_last,
    output logic                              line_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clu_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [clu_pkg::DATA_BITS-1:0]     pwdata,
    output logic [clu_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready
);

    localparam logic [clu_pkg::LINE_W_BITS-1:0] MAX_W = clu_pkg::LINE_W_BITS'(MAX_LINE_WIDTH);

    logic [clu_pkg::LINE_W_BITS-1:0] width_reg;
    logic [clu_pkg::LINE_W_BITS-1:0] width_next;
    logic [clu_pkg::COL_BITS-1:0]    col_reg;
    logic [clu_pkg::COL_BITS-1:0]    col_next;
    clu_pkg::chroma_t                prev_above_reg;
    clu_pkg::chroma_t                prev_here_reg;

    logic                            cfg_write;
    logic [clu_pkg::LINE_W_BITS-1:0] wr_w;
    logic                            accept;
    logic [clu_pkg::LINE_W_BITS-1:0] cols;
    logic [clu_pkg::LINE_W_BITS-1:0] col_plus;
    logic                            last_col;
    logic                            trailing;
    logic [clu_pkg::LINE_W_BITS-1:0] col_x2;

    clu_pkg::chroma_t cur_above;
    clu_pkg::chroma_t cur_here;
    clu_pkg::chroma_t edge_c;
    clu_pkg::chroma_t left_c;
    clu_pkg::chroma_t right_c;
    clu_pkg::pixel_t  edge_px;
    clu_pkg::pixel_t  trail_px;
    clu_pkg::batch_t  batch;
    clu_pkg::pixel_t  pixel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == clu_pkg::REG_LINE_WIDTH);
    assign prdata    = (paddr[2] == clu_pkg::REG_LINE_WIDTH)
                     ? {{(clu_pkg::DATA_BITS-clu_pkg::LINE_W_BITS){1'b0}}, width_reg}
                     : '0;

    always_comb
    begin
        wr_w = pwdata[clu_pkg::LINE_W_BITS-1:0];
        priority if (wr_w == '0)
            width_next = clu_pkg::LINE_W_BITS'(1);
        else if (wr_w > MAX_W)
            width_next = MAX_W;
        else
            width_next = wr_w;
    end

    assign cur_above = '{u: above_u, v: above_v};
    assign cur_here  = '{u: here_u,  v: here_v};

    clu_lane u_lane_edge
    (
        .odd        (mode),
        .above_near (cur_above),
        .above_far  (cur_above),
        .here_near  (cur_here),
        .here_far   (cur_here),
        .result     (edge_c)
    );

    clu_lane u_lane_left
    (
        .odd        (mode),
        .above_near (prev_above_reg),
        .above_far  (cur_above),
        .here_near  (prev_here_reg),
        .here_far   (cur_here),
        .result     (left_c)
    );

    clu_lane u_lane_right
    (
        .odd        (mode),
        .above_near (cur_above),
        .above_far  (prev_above_reg),
        .here_near  (cur_here),
        .here_far   (prev_here_reg),
        .result     (right_c)
    );

    assign cols     = clu_pkg::LINE_W_BITS'(({1'b0, width_reg} + 15'd1) >> 1);
    assign col_plus = {1'b0, col_reg} + clu_pkg::LINE_W_BITS'(1);
    assign last_col = (col_plus >= cols);
    assign trailing = last_col && !width_reg[0];
    assign col_x2   = {col_reg, 1'b0};
    assign col_next = last_col ? '0 : col_plus[clu_pkg::COL_BITS-1:0];

    always_comb
    begin
        edge_px  = '{c: edge_c, col: '0, line_last: last_col && !trailing};
        trail_px = '{c: edge_c, col: width_reg - clu_pkg::LINE_W_BITS'(1), line_last: 1'b1};
        if (col_reg == '0)
        begin
            batch.pix[0] = edge_px;
            batch.pix[1] = trail_px;
            batch.pix[2] = trail_px;
            batch.cnt    = trailing ? 2'd2 : 2'd1;
        end
        else
        begin
            batch.pix[0] = '{c: left_c, col: col_x2 - clu_pkg::LINE_W_BITS'(1), line_last: 1'b0};
            batch.pix[1] = '{c: right_c, col: col_x2, line_last: last_col && !trailing};
            batch.pix[2] = trail_px;
            batch.cnt    = trailing ? 2'd3 : 2'd2;
        end
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= clu_pkg::LINE_W_BITS'(1);
            col_reg        <= '0;
            prev_above_reg <= '0;
            prev_here_reg  <= '0;
        end
        else if (cfg_write)
        begin
            width_reg <= width_next;
            col_reg   <= '0;
        end
        else if (accept)
        begin
            col_reg        <= col_next;
            prev_above_reg <= cur_above;
            prev_here_reg  <= cur_here;
        end
    end

    clu_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .batch     (batch),
        .take_ok   (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel     (pixel),
        .run_last  (run_last)
    );

    assign u_out        = pixel.c.u;
    assign v_out        = pixel.c.v;
    assign pixel_column = pixel.col;
    assign line_last    = pixel.line_last;

endmodule
